// File: rtl/core/lsq_pkg.sv
// Shared types, constants and helpers of the load/store queue.
package lsq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 168;

    localparam logic [4:0] CAP_RESET         = 5'd16;
    localparam logic [3:0] LOAD_PORTS_RESET  = 4'd2;
    localparam logic [3:0] STORE_PORTS_RESET = 4'd1;

    // register indexes (byte address = index * 4)
    localparam logic [1:0] REG_CAP    = 2'd0;
    localparam logic [1:0] REG_LPORTS = 2'd1;
    localparam logic [1:0] REG_SPORTS = 2'd2;

    typedef enum logic [2:0] {
        ACT_ADD_LOAD  = 3'd0,
        ACT_ADD_STORE = 3'd1,
        ACT_COMPLETE  = 3'd2,
        ACT_CONFLICT  = 3'd3,
        ACT_ISSUE     = 3'd4,
        ACT_RETIRE    = 3'd5,
        ACT_TICK      = 3'd6,
        ACT_CLEAR     = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        REP_ADD      = 3'd0,
        REP_COMPLETE = 3'd1,
        REP_CONFLICT = 3'd2,
        REP_ISSUE    = 3'd3,
        REP_RETIRE   = 3'd4
    } t_reply;

    typedef struct packed {
        logic [15:0] tag;
        logic [63:0] addr;
        logic [7:0]  size;
        logic        is_load;
        logic        done;
        logic [31:0] itime;
        logic [31:0] ctime;
    } t_entry;

    typedef struct packed {
        logic [63:0] addr;
        logic [7:0]  size;
    } t_query;

    typedef struct packed {
        logic wr;
        logic cmpl;
        logic tok_load;
        logic tok_sel;
        logic tok_adv;
    } t_cell_ctl;

    typedef struct packed {
        t_reply      kind;
        logic        success;
        logic [3:0]  slot;
        logic [15:0] tag;
        logic [63:0] addr;
        logic [7:0]  size;
        logic        is_load;
        logic [31:0] itime;
        logic [31:0] ctime;
        logic        last;
        logic [4:0]  fill;
    } t_result;

    // a < b + t, exact (no wrap)
    function automatic logic below_end(logic [63:0] a, logic [63:0] b, logic [7:0] t);
        logic [63:0] d;
        d = a - b;
        return (a < b) || ((d[63:8] == 56'd0) && (d[7:0] < t));
    endfunction

    function automatic t_result make_result(t_reply kind, logic ok, logic [3:0] slot,
                                            t_entry e, logic [31:0] ctime,
                                            logic [4:0] fill);
        t_result r;
        r         = '0;
        r.kind    = kind;
        r.success = ok;
        r.fill    = fill;
        if (ok) begin
            r.slot    = slot;
            r.tag     = e.tag;
            r.addr    = e.addr;
            r.size    = e.size;
            r.is_load = e.is_load;
            r.itime   = e.itime;
            r.ctime   = ctime;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/lsq_cell.sv
// One queue slot: entry storage, local store-overlap compare and scan token stage.
module lsq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lsq_pkg::t_cell_ctl i_ctl,
    input  lsq_pkg::t_entry   i_wdata,
    input  logic [31:0]       i_ctime,
    input  lsq_pkg::t_query   i_query,
    input  logic              i_tok_prev,
    output logic              o_tok,
    output lsq_pkg::t_entry   o_entry,
    output logic              o_match
);
    import lsq_pkg::*;

    t_entry r_entry;
    logic   r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else if (i_ctl.tok_load) begin
            r_tok <= i_ctl.tok_sel;
        end else if (i_ctl.tok_adv) begin
            r_tok <= i_tok_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_entry <= i_wdata;
        end else if (i_ctl.cmpl) begin
            r_entry.done  <= 1'b1;
            r_entry.ctime <= i_ctime;
        end
    end

    // pending store overlapping the query range
    assign o_match = !r_entry.is_load && !r_entry.done
                  && below_end(i_query.addr, r_entry.addr, r_entry.size)
                  && below_end(r_entry.addr, i_query.addr, i_query.size);

    assign o_tok   = r_tok;
    assign o_entry = r_entry;

endmodule

// File: rtl/core/load_store_queue.sv
// Top level of the load/store queue: request sequencer, cell row and ports.
//
// In-order ring of QUEUE_DEPTH load/store entries held in a row of slot cells.
// Requests arrive on the slave stream (action in tuser) and results leave on the
// master stream, tlast on the final result of a request. Add, tick and clear are
// handled in the idle state; complete parks a scan token on the slot, then reads it.
// Conflict check, issue and retire move a one-hot token from cell to cell, one
// entry per cycle from the head; issue and retire wait while an earlier result is
// still untaken. Retire first counts the done run at the head, then walks it again
// to emit one result per retired entry. One request is in work at a time and a new
// one is taken only once the result register is empty. Configuration goes through
// the APB port and is meant to be written while no request is in work.
module load_store_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [lsq_pkg::IN_DATA_W-1:0]  i_s_tdata,  // instr_tag, address, access_size,
                                                       // slot, zero pad
    input  logic [2:0]  i_s_tuser,   // action
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [lsq_pkg::OUT_DATA_W-1:0] o_m_tdata,  // success, entry_slot, entry_tag,
                                     // entry_address, entry_size, entry_is_load,
                                     // issued_at, completed_at, fill_level, zero pad
    output logic [2:0]  o_m_tuser,   // reply_kind
    output logic        o_m_tlast,   // last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lsq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CMPL, ST_CONF, ST_ISSUE, ST_FLUSH, ST_RCNT, ST_REMIT
    } t_state;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [3:0]        r_lif, n_lif, r_sif, n_sif;
    logic [31:0]       r_cycle, n_cycle;
    logic [4:0]        r_cap, n_cap;
    logic [3:0]        r_lp, n_lp, r_sp, n_sp;
    t_query            r_q, n_q;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [SLOT_W-1:0] r_pos, n_pos;
    logic [RES_W-1:0]  r_k, n_k, r_n, n_n;
    logic [3:0]        r_li, n_li, r_si, n_si;
    logic              r_pv, n_pv;
    t_result           r_pend, n_pend;
    logic              r_ovalid, n_ovalid;
    t_result           r_out;

    // cell row
    t_cell_ctl         ctl [QUEUE_DEPTH];
    t_entry            cell_ent [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] tok, match;
    t_entry            wdata, tok_ent;
    logic              tok_match;

    // sequencer controls
    logic              wr_go, cmpl_go, tok_load, tok_adv;
    logic [SLOT_W-1:0] wr_slot, tok_idx, pos_next;
    logic              push, push_last;
    t_result           push_res;
    logic              out_free, accept, held, elig;

    logic [15:0] in_tag;
    logic [63:0] in_addr;
    logic [7:0]  in_size;
    logic [3:0]  in_slot;
    t_action     in_act;

    assign in_tag  = i_s_tdata[15:0];
    assign in_addr = i_s_tdata[79:16];
    assign in_size = i_s_tdata[87:80];
    assign in_slot = i_s_tdata[91:88];
    assign in_act  = t_action'(i_s_tuser);

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            always_comb begin
                ctl[g].wr       = wr_go && (wr_slot == SLOT_W'(g));
                ctl[g].cmpl     = cmpl_go && tok[g];
                ctl[g].tok_load = tok_load;
                ctl[g].tok_sel  = (tok_idx == SLOT_W'(g));
                ctl[g].tok_adv  = tok_adv;
            end
            lsq_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl[g]),
                .i_wdata    (wdata),
                .i_ctime    (r_cycle),
                .i_query    (r_q),
                .i_tok_prev (tok[(g + QUEUE_DEPTH - 1) % QUEUE_DEPTH]),
                .o_tok      (tok[g]),
                .o_entry    (cell_ent[g]),
                .o_match    (match[g])
            );
        end
    endgenerate

    // entry under the token
    always_comb begin
        tok_ent = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            tok_ent = t_entry'(tok_ent | (cell_ent[k] & {$bits(t_entry){tok[k]}}));
        end
    end
    assign tok_match = |(match & tok);

    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign accept     = i_s_tvalid && o_s_tready;
    assign pos_next   = (r_pos == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : r_pos + 1'b1;

    assign elig = tok_ent.is_load ? ((r_li < r_lp) && (r_lif < r_lp))
                                  : ((r_si < r_sp) && (r_sif < r_sp));

    always_comb begin
        int sum;
        int off;
        n_state  = r_state;
        n_head   = r_head;
        n_fill   = r_fill;
        n_lif    = r_lif;
        n_sif    = r_sif;
        n_cycle  = r_cycle;
        n_cap    = r_cap;
        n_lp     = r_lp;
        n_sp     = r_sp;
        n_q      = r_q;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_k      = r_k;
        n_n      = r_n;
        n_li     = r_li;
        n_si     = r_si;
        n_pv     = r_pv;
        n_pend   = r_pend;
        wr_go    = 1'b0;
        cmpl_go  = 1'b0;
        tok_load = 1'b0;
        tok_adv  = 1'b0;
        tok_idx  = r_head;
        push     = 1'b0;
        push_last = 1'b1;
        push_res = '0;
        sum      = 32'(r_head) + 32'(r_fill);
        if (sum >= QUEUE_DEPTH) begin
            sum = sum - QUEUE_DEPTH;
        end
        wr_slot  = SLOT_W'(sum);
        off      = 32'(in_slot) - 32'(r_head);
        if (off < 0) begin
            off = off + QUEUE_DEPTH;
        end
        held     = (32'(in_slot) < QUEUE_DEPTH) && (off < 32'(r_fill));
        wdata.tag     = in_tag;
        wdata.addr    = in_addr;
        wdata.size    = in_size;
        wdata.is_load = (in_act == ACT_ADD_LOAD);
        wdata.done    = 1'b0;
        wdata.itime   = r_cycle;
        wdata.ctime   = 32'd0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (in_act)
                        ACT_ADD_LOAD, ACT_ADD_STORE: begin
                            push = 1'b1;
                            if ((32'(r_fill) < 32'(r_cap)) && (32'(r_fill) < QUEUE_DEPTH)) begin
                                wr_go    = 1'b1;
                                n_fill   = r_fill + 1'b1;
                                push_res = make_result(REP_ADD, 1'b1, 4'(wr_slot), wdata,
                                                       32'd0, 5'(r_fill + 1'b1));
                            end else begin
                                push_res = make_result(REP_ADD, 1'b0, 4'd0, '0, 32'd0,
                                                       5'(r_fill));
                            end
                        end
                        ACT_COMPLETE: begin
                            if (held) begin
                                tok_load = 1'b1;
                                tok_idx  = SLOT_W'(in_slot);
                                n_pos    = SLOT_W'(in_slot);
                                n_state  = ST_CMPL;
                            end else begin
                                push     = 1'b1;
                                push_res = make_result(REP_COMPLETE, 1'b0, 4'd0, '0, 32'd0,
                                                       5'(r_fill));
                            end
                        end
                        ACT_CONFLICT: begin
                            n_q.addr = in_addr;
                            n_q.size = in_size;
                            tok_load = 1'b1;
                            n_pos    = r_head;
                            n_idx    = '0;
                            n_state  = ST_CONF;
                        end
                        ACT_ISSUE: begin
                            tok_load = 1'b1;
                            n_pos    = r_head;
                            n_idx    = '0;
                            n_n      = '0;
                            n_li     = '0;
                            n_si     = '0;
                            n_pv     = 1'b0;
                            n_state  = ST_ISSUE;
                        end
                        ACT_RETIRE: begin
                            tok_load = 1'b1;
                            n_pos    = r_head;
                            n_idx    = '0;
                            n_k      = '0;
                            n_state  = ST_RCNT;
                        end
                        ACT_TICK: begin
                            n_cycle = r_cycle + 32'd1;
                        end
                        ACT_CLEAR: begin
                            n_head = '0;
                            n_fill = '0;
                            n_lif  = '0;
                            n_sif  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CMPL: begin
                cmpl_go = 1'b1;
                if (tok_ent.is_load) begin
                    n_lif = (r_lif != 4'd0) ? r_lif - 4'd1 : 4'd0;
                end else begin
                    n_sif = (r_sif != 4'd0) ? r_sif - 4'd1 : 4'd0;
                end
                push     = 1'b1;
                push_res = make_result(REP_COMPLETE, 1'b1, 4'(r_pos), tok_ent, r_cycle,
                                       5'(r_fill));
                n_state  = ST_IDLE;
            end
            ST_CONF: begin
                if (r_idx == r_fill) begin
                    push     = 1'b1;
                    push_res = make_result(REP_CONFLICT, 1'b0, 4'd0, '0, 32'd0, 5'(r_fill));
                    n_state  = ST_IDLE;
                end else if (tok_match) begin
                    push     = 1'b1;
                    push_res = make_result(REP_CONFLICT, 1'b1, 4'(r_pos), tok_ent, 32'd0,
                                           5'(r_fill));
                    n_state  = ST_IDLE;
                end else begin
                    tok_adv = 1'b1;
                    n_idx   = r_idx + 1'b1;
                    n_pos   = pos_next;
                end
            end
            ST_ISSUE: begin
                if ((r_idx == r_fill) || (32'(r_n) == MAX_RESULTS)) begin
                    n_state = ST_FLUSH;
                end else if (!tok_ent.done && elig) begin
                    // the held result goes out once we know another follows
                    if (!r_pv || out_free) begin
                        push      = r_pv;
                        push_last = 1'b0;
                        push_res  = r_pend;
                        n_pend    = make_result(REP_ISSUE, 1'b1, 4'(r_pos), tok_ent, 32'd0,
                                                5'(r_fill));
                        n_pv      = 1'b1;
                        n_n       = r_n + 1'b1;
                        if (tok_ent.is_load) begin
                            n_li  = r_li + 4'd1;
                            n_lif = r_lif + 4'd1;
                        end else begin
                            n_si  = r_si + 4'd1;
                            n_sif = r_sif + 4'd1;
                        end
                        tok_adv = 1'b1;
                        n_idx   = r_idx + 1'b1;
                        n_pos   = pos_next;
                    end
                end else begin
                    tok_adv = 1'b1;
                    n_idx   = r_idx + 1'b1;
                    n_pos   = pos_next;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    push     = 1'b1;
                    push_res = r_pv ? r_pend
                                    : make_result(REP_ISSUE, 1'b0, 4'd0, '0, 32'd0,
                                                  5'(r_fill));
                    n_pv     = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            ST_RCNT: begin
                // count the done run at the head first: every result carries the final fill
                if ((r_idx < r_fill) && (32'(r_k) < MAX_RESULTS) && tok_ent.done) begin
                    n_k     = r_k + 1'b1;
                    tok_adv = 1'b1;
                    n_idx   = r_idx + 1'b1;
                    n_pos   = pos_next;
                end else if (r_k == '0) begin
                    push     = 1'b1;
                    push_res = make_result(REP_RETIRE, 1'b0, 4'd0, '0, 32'd0, 5'(r_fill));
                    n_state  = ST_IDLE;
                end else begin
                    tok_load = 1'b1;
                    n_pos    = r_head;
                    n_idx    = '0;
                    n_state  = ST_REMIT;
                end
            end
            ST_REMIT: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_last = (32'(r_idx) + 1 == 32'(r_k));
                    push_res  = make_result(REP_RETIRE, 1'b1, 4'(r_pos), tok_ent,
                                            tok_ent.ctime, 5'(r_fill - CNT_W'(r_k)));
                    tok_adv   = 1'b1;
                    n_idx     = r_idx + 1'b1;
                    n_pos     = pos_next;
                    if (push_last) begin
                        sum = 32'(r_head) + 32'(r_k);
                        if (sum >= QUEUE_DEPTH) begin
                            sum = sum - QUEUE_DEPTH;
                        end
                        n_head  = SLOT_W'(sum);
                        n_fill  = r_fill - CNT_W'(r_k);
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        push_res.last = push_last;

        // configuration writes
        if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_CAP:    n_cap = pwdata[4:0];
                REG_LPORTS: n_lp  = pwdata[3:0];
                REG_SPORTS: n_sp  = pwdata[3:0];
                default: begin
                end
            endcase
        end

        if (push) begin
            n_ovalid = 1'b1;
        end else if (i_m_tready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    // state, control and payload registers; payload has no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_fill   <= '0;
            r_lif    <= '0;
            r_sif    <= '0;
            r_cycle  <= '0;
            r_cap    <= CAP_RESET;
            r_lp     <= LOAD_PORTS_RESET;
            r_sp     <= STORE_PORTS_RESET;
            r_idx    <= '0;
            r_pos    <= '0;
            r_k      <= '0;
            r_n      <= '0;
            r_li     <= '0;
            r_si     <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_lif    <= n_lif;
            r_sif    <= n_sif;
            r_cycle  <= n_cycle;
            r_cap    <= n_cap;
            r_lp     <= n_lp;
            r_sp     <= n_sp;
            r_idx    <= n_idx;
            r_pos    <= n_pos;
            r_k      <= n_k;
            r_n      <= n_n;
            r_li     <= n_li;
            r_si     <= n_si;
            r_pv     <= n_pv;
            r_ovalid <= n_ovalid;
            r_q      <= n_q;
            r_pend   <= n_pend;
            if (push) begin
                r_out <= push_res;
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {5'd0, r_out.fill, r_out.ctime, r_out.itime, r_out.is_load,
                         r_out.size, r_out.addr, r_out.tag, r_out.slot, r_out.success};

    assign pready = 1'b1;
    always_comb begin
        case (paddr[3:2])
            REG_CAP:    prdata = {27'd0, r_cap};
            REG_LPORTS: prdata = {28'd0, r_lp};
            REG_SPORTS: prdata = {28'd0, r_sp};
            default:    prdata = 32'd0;
        endcase
    end

    // scan token is never in two cells
    a_tok_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok))
        else $error("scan token in more than one cell");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= QUEUE_DEPTH)
        else $error("fill count above depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_act == ACT_CLEAR)) |=> (r_fill == '0) && (r_head == '0))
        else $error("clear did not empty the queue");

    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> ((r_state == ST_ISSUE) || (r_state == ST_FLUSH)))
        else $error("held issue result outside issue scan");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("result pushed over an untaken result");

endmodule
